>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared forms for concurrent checks clocked on clk with active-low rst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is switched off while reset is held
`define ABDR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("abdr check failed");

// check that holds at every edge, reset included
`define ABDR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("abdr check failed");

`endif

>>> hw/rtl/abdr_pkg.sv
// ---------------------------------------------------------------------------
// abdr_pkg
// shared types, constants and register codes of the bit depth requantizer
// ---------------------------------------------------------------------------
package abdr_pkg;

    // sample width and derived widths
    localparam int SAMPLE_BITS = 32;
    localparam int KW          = 6;
    localparam int MW          = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    typedef logic [SAMPLE_BITS-1:0]   word_t;
    typedef logic [2*SAMPLE_BITS-1:0] dword_t;

    localparam word_t HALF     = word_t'(1) << (SAMPLE_BITS - 1);
    localparam word_t ALL_ONES = '1;

    // correction mode codes (the unused code behaves as truncate)
    localparam logic [MW-1:0] MODE_SPREAD = 2'd0;
    localparam logic [MW-1:0] MODE_GRID   = 2'd1;
    localparam logic [MW-1:0] MODE_TRUNC  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEPT_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORR_MODE = 2'd1;

    // reset values
    localparam logic [KW-1:0] KEPT_RESET = 6'd16;
    localparam logic [MW-1:0] MODE_RESET = MODE_TRUNC;

    // derived configuration seen by every stage
    typedef struct packed {
        logic [KW-1:0] k;     // clamped kept bits
        logic [KW-1:0] b;     // cleared low bits
        word_t         lm;    // mask of the cleared bits
        word_t         m;     // 2^k - 1
        logic [MW-1:0] mode;
    } cfg_t;

    // side information that travels with each word
    typedef struct packed {
        logic [MW-1:0] mode;
        word_t         aux;   // cleared sample for spread, result for truncate
    } side_t;

endpackage

>>> hw/rtl/abdr_front.sv
// ---------------------------------------------------------------------------
// abdr_front
// four stage front end: offset, grid rounding and dividend set-up
// ---------------------------------------------------------------------------
module abdr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  abdr_pkg::word_t      in_data,
    input  abdr_pkg::cfg_t       cfg,
    output logic                 out_valid,
    output abdr_pkg::side_t      out_side,
    output abdr_pkg::word_t      out_hi,
    output abdr_pkg::word_t      out_lo
);

    localparam int SB = abdr_pkg::SAMPLE_BITS;

    // stage 1 registers
    logic              v1_reg;
    abdr_pkg::side_t   side1_reg, side1_next;
    abdr_pkg::dword_t  x1_reg, x1_next;
    abdr_pkg::word_t   kval1_reg, kval1_next;
    // stage 2 registers
    logic              v2_reg;
    abdr_pkg::side_t   side2_reg;
    abdr_pkg::word_t   num2_reg, num2_next;
    abdr_pkg::word_t   h2_reg;
    logic [SB:0]       s2_reg, s2_next;
    // stage 3 registers
    logic              v3_reg;
    abdr_pkg::side_t   side3_reg;
    abdr_pkg::word_t   num3_reg;
    abdr_pkg::word_t   q3_reg, q3_next;
    // stage 4 registers
    logic              v4_reg;
    abdr_pkg::side_t   side4_reg;
    abdr_pkg::dword_t  dvd4_reg, dvd4_next;

    abdr_pkg::word_t   u;
    abdr_pkg::word_t   cleared;
    abdr_pkg::word_t   rem3;
    logic [1:0]        carry3;
    logic              rnd3;

    // stage 1: offset binary, u * (2^k - 1), cleared word
    always_comb
    begin
        u          = in_data ^ abdr_pkg::HALF;
        cleared    = u & ~cfg.lm;
        x1_next    = ({{SB{1'b0}}, u} << cfg.k) - {{SB{1'b0}}, u};
        kval1_next = u >> cfg.b;
        side1_next.mode = cfg.mode;
        if (cfg.mode == abdr_pkg::MODE_SPREAD)
        begin
            side1_next.aux = cleared;
        end
        else
        begin
            side1_next.aux = cleared + (cfg.lm >> 1);
        end
    end

    // stage 2: spread numerator and folded sum for the divide by 2^N - 1
    always_comb
    begin
        num2_next = (kval1_reg << cfg.b) - kval1_reg;
        s2_next   = {1'b0, x1_reg[2*SB-1:SB]} + {1'b0, x1_reg[SB-1:0]};
    end

    // stage 3: finish divide by 2^N - 1 and round half up
    always_comb
    begin
        if (s2_reg >= {abdr_pkg::ALL_ONES, 1'b0})
        begin
            carry3 = 2'd2;
            rem3   = SB'(s2_reg - {abdr_pkg::ALL_ONES, 1'b0});
        end
        else if (s2_reg >= {1'b0, abdr_pkg::ALL_ONES})
        begin
            carry3 = 2'd1;
            rem3   = SB'(s2_reg - {1'b0, abdr_pkg::ALL_ONES});
        end
        else
        begin
            carry3 = 2'd0;
            rem3   = s2_reg[SB-1:0];
        end
        rnd3    = ({rem3, 1'b0} >= {1'b0, abdr_pkg::ALL_ONES});
        q3_next = h2_reg + SB'(carry3) + SB'(rnd3);
    end

    // stage 4: dividend for the divide by 2^k - 1
    always_comb
    begin
        if (side3_reg.mode == abdr_pkg::MODE_GRID)
        begin
            dvd4_next = {q3_reg, {SB{1'b0}}} - {{SB{1'b0}}, q3_reg};
        end
        else
        begin
            dvd4_next = {{SB{1'b0}}, num3_reg};
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side1_next;
            x1_reg    <= x1_next;
            kval1_reg <= kval1_next;
            side2_reg <= side1_reg;
            num2_reg  <= num2_next;
            h2_reg    <= x1_reg[2*SB-1:SB];
            s2_reg    <= s2_next;
            side3_reg <= side2_reg;
            num3_reg  <= num2_reg;
            q3_reg    <= q3_next;
            side4_reg <= side3_reg;
            dvd4_reg  <= dvd4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_side  = side4_reg;
    assign out_hi    = dvd4_reg[2*SB-1:SB];
    assign out_lo    = dvd4_reg[SB-1:0];

endmodule

>>> hw/rtl/abdr_divider.sv
// ---------------------------------------------------------------------------
// abdr_divider
// pipelined restoring divider by 2^k - 1, one quotient bit per stage
// ---------------------------------------------------------------------------
module abdr_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  abdr_pkg::word_t      divisor,
    input  logic                 in_valid,
    input  abdr_pkg::side_t      in_side,
    input  abdr_pkg::word_t      in_hi,
    input  abdr_pkg::word_t      in_lo,
    output logic                 out_valid,
    output abdr_pkg::side_t      out_side,
    output abdr_pkg::word_t      out_quot,
    output abdr_pkg::word_t      out_rem
);

    localparam int SB = abdr_pkg::SAMPLE_BITS;

    logic              v_reg    [SB];
    abdr_pkg::side_t   side_reg [SB];
    abdr_pkg::word_t   r_reg    [SB];
    abdr_pkg::word_t   q_reg    [SB];

    logic              v_in     [SB];
    abdr_pkg::side_t   side_in  [SB];
    abdr_pkg::word_t   r_in     [SB];
    abdr_pkg::word_t   q_in     [SB];

    genvar g;
    generate
        for (g = 0; g < SB; g++)
        begin : g_stage
            logic [SB:0]     trial;
            logic            ge;
            abdr_pkg::word_t r_next;
            abdr_pkg::word_t q_next;

            // stage input
            if (g == 0)
            begin : g_first
                assign v_in[g]    = in_valid;
                assign side_in[g] = in_side;
                assign r_in[g]    = in_hi;
                assign q_in[g]    = in_lo;
            end
            else
            begin : g_next
                assign v_in[g]    = v_reg[g-1];
                assign side_in[g] = side_reg[g-1];
                assign r_in[g]    = r_reg[g-1];
                assign q_in[g]    = q_reg[g-1];
            end

            // shift in one dividend bit, subtract if it fits
            always_comb
            begin
                trial  = {r_in[g], q_in[g][SB-1]};
                ge     = (trial >= {1'b0, divisor});
                r_next = ge ? SB'(trial - {1'b0, divisor}) : trial[SB-1:0];
                q_next = {q_in[g][SB-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[g] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[g] <= v_in[g];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[g] <= side_in[g];
                    r_reg[g]    <= r_next;
                    q_reg[g]    <= q_next;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[SB-1];
    assign out_side  = side_reg[SB-1];
    assign out_quot  = q_reg[SB-1];
    assign out_rem   = r_reg[SB-1];

endmodule

>>> hw/rtl/abdr_back.sv
// ---------------------------------------------------------------------------
// abdr_back
// final rounding, mode select and output register with skid stage
// ---------------------------------------------------------------------------
module abdr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  abdr_pkg::word_t      divisor,
    input  logic                 in_valid,
    input  abdr_pkg::side_t      in_side,
    input  abdr_pkg::word_t      in_quot,
    input  abdr_pkg::word_t      in_rem,
    output logic                 en,
    output logic                 out_valid,
    input  logic                 out_ready,
    output abdr_pkg::word_t      out_data
);

    logic            out_valid_reg, out_valid_next;
    abdr_pkg::word_t out_data_reg, out_data_next;
    logic            skid_valid_reg, skid_valid_next;
    abdr_pkg::word_t skid_data_reg, skid_data_next;

    abdr_pkg::word_t fill;
    abdr_pkg::word_t v;
    abdr_pkg::word_t result;
    logic            rnd;
    logic            out_free;

    // result of the word leaving the divider
    always_comb
    begin
        rnd  = ({in_rem, 1'b0} >= {1'b0, divisor});
        fill = in_quot + abdr_pkg::SAMPLE_BITS'(rnd);
        unique case (in_side.mode)
            abdr_pkg::MODE_SPREAD: v = in_side.aux | fill;
            abdr_pkg::MODE_GRID:   v = in_quot;
            default:               v = in_side.aux;
        endcase
        result = v ^ abdr_pkg::HALF;
    end

    // output register and skid stage
    always_comb
    begin
        en              = !skid_valid_reg;
        out_free        = !out_valid_reg || out_ready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = result;
            end
        end
        else if (en && in_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hw/rtl/audio_bit_depth_requantizer_top.sv
// ---------------------------------------------------------------------------
// audio_bit_depth_requantizer_top
// requantizes signed Q1.31 samples to a programmable number of kept bits
// ---------------------------------------------------------------------------
// The block takes one sample per clock and returns one requantized sample
// per input, in order. The path runs through a four stage front end, a
// 32 stage divider by 2^K - 1 that resolves one quotient bit per stage, and
// the output register. A skid stage behind the output register takes one
// more word while a result waits; once it holds a word the input stalls,
// and it takes words again in the cycle after the waiting result has been
// taken.
// kept_bits and correction_mode are written through the cfg port, which is
// always ready; write them only while no sample is in flight.
module audio_bit_depth_requantizer_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  abdr_pkg::word_t                  s_axis_tdata,  // [31:0] sample_in
    // master side
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output abdr_pkg::word_t                  m_axis_tdata,  // [31:0] sample_out
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [abdr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [abdr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int KW = abdr_pkg::KW;

    logic [KW-1:0]           kept_reg;
    logic [abdr_pkg::MW-1:0] mode_reg;
    abdr_pkg::cfg_t          cfg;
    logic [KW-1:0]           k_clamped;
    logic                    en;

    logic                    f_valid;
    abdr_pkg::side_t         f_side;
    abdr_pkg::word_t         f_hi;
    abdr_pkg::word_t         f_lo;

    logic                    d_valid;
    abdr_pkg::side_t         d_side;
    abdr_pkg::word_t         d_quot;
    abdr_pkg::word_t         d_rem;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg <= abdr_pkg::KEPT_RESET;
            mode_reg <= abdr_pkg::MODE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                abdr_pkg::REG_KEPT_BITS: kept_reg <= cfg_data[KW-1:0];
                abdr_pkg::REG_CORR_MODE: mode_reg <= cfg_data[abdr_pkg::MW-1:0];
                default:                 ;
            endcase
        end
    end

    // clamp kept bits and derive masks
    always_comb
    begin
        if (kept_reg == '0)
        begin
            k_clamped = KW'(1);
        end
        else if (kept_reg > KW'(abdr_pkg::SAMPLE_BITS))
        begin
            k_clamped = KW'(abdr_pkg::SAMPLE_BITS);
        end
        else
        begin
            k_clamped = kept_reg;
        end
        cfg.k    = k_clamped;
        cfg.b    = KW'(abdr_pkg::SAMPLE_BITS) - k_clamped;
        cfg.lm   = abdr_pkg::ALL_ONES >> k_clamped;
        cfg.m    = abdr_pkg::ALL_ONES >> cfg.b;
        cfg.mode = mode_reg;
    end

    assign s_axis_tready = en;

    abdr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid && en),
        .in_data   (s_axis_tdata),
        .cfg       (cfg),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_hi    (f_hi),
        .out_lo    (f_lo)
    );

    abdr_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .divisor   (cfg.m),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_hi     (f_hi),
        .in_lo     (f_lo),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_quot  (d_quot),
        .out_rem   (d_rem)
    );

    abdr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .divisor   (cfg.m),
        .in_valid  (d_valid),
        .in_side   (d_side),
        .in_quot   (d_quot),
        .in_rem    (d_rem),
        .en        (en),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

>>> hw/rtl/abdr_checker.sv
// ---------------------------------------------------------------------------
// abdr_checker
// port level checks of the requantizer, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module abdr_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tready,
    input  logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    input  abdr_pkg::word_t m_axis_tdata,
    input  logic            cfg_ready
);

    // a stalled output word holds
    `ABDR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

    // input back-pressure only while a result sits at the output
    `ABDR_ASSERT(a_stall_needs_out, !s_axis_tready |-> m_axis_tvalid)

    // input back-pressure starts only after an output stall
    `ABDR_ASSERT(a_stall_cause, $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))

    // configuration writes are never refused
    `ABDR_ASSERT_ALWAYS(a_cfg_ready, cfg_ready)

endmodule

bind audio_bit_depth_requantizer_top abdr_checker u_abdr_checker (.*);
